// ===== rtl/core/fsht_pkg.sv =====
// shared types and constants for the fold-shift hash table insert engine
package fsht_pkg;

  localparam int SLOTS      = 256;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int ID_W       = 10;
  localparam int CNT_W      = 10;
  localparam int SUM_W      = 12;
  localparam int BITCNT_W   = $clog2(SUM_W);
  localparam int ALU_W      = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(101);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SLOTS);
  localparam logic [ALU_W-1:0]  PROBE_STEP = ALU_W'(7);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_HOME,
    ST_CNT_UPD,
    ST_PADD,
    ST_PCHK,
    ST_PLACE,
    ST_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              clear_all;
    logic              occ_set;
    logic [ADDR_W-1:0] set_addr;
    logic              ent_we;
    logic [ID_W-1:0]   ent_wdata;
    logic              cnt_we;
    logic [ADDR_W-1:0] cnt_addr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] prb_addr;
  } store_req_t;

endpackage

// ===== rtl/core/fold_shift_hash_table_insert_top.sv =====
// fold-shift hash table insert engine: sequencer, working registers and result register
//
//   channel | direction | handshake           | payload
//   in_     | request   | in_valid / in_stall  | mode, digit0..5, entry_id, slot_index
//   out_    | result    | out_valid / out_stall| home_slot .. slot_collisions
//   cfg_    | write     | cfg_wr_en            | table_size
//
// insert: 12 remainder steps on the shared adder, one home check, one count update
// on collision, then a step and a bound check per probe, one write, one hand-off.
// read goes through a read and a read-wait state to the hand-off; clear and the unused
// mode go straight to the hand-off; a clear resets all occupancy flags together.
// reset is synchronous; a new request is taken while the last result is still stalled.
module fold_shift_hash_table_insert_top
  import fsht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [3:0]        in_digit0,
  input  logic [3:0]        in_digit1,
  input  logic [3:0]        in_digit2,
  input  logic [3:0]        in_digit3,
  input  logic [3:0]        in_digit4,
  input  logic [3:0]        in_digit5,
  input  logic [ID_W-1:0]   in_entry_id,
  input  logic [ADDR_W-1:0] in_slot_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_home_slot,
  output logic [ADDR_W-1:0] out_placed_slot,
  output logic              out_collided,
  output logic              out_fell_back,
  output logic              out_slot_occupied,
  output logic [ID_W-1:0]   out_slot_entry,
  output logic [CNT_W-1:0]  out_slot_collisions
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]   size_r;
  logic [SIZE_W-1:0]   size_eff;
  mode_t               mode_in;
  logic                accept;
  logic                out_free;

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ADDR_W-1:0]   rem_r, rem_nxt;
  logic [BITCNT_W-1:0] bit_r, bit_nxt;
  logic [SIZE_W-1:0]   j_r, j_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [ADDR_W-1:0]   home_r, home_nxt;
  logic [ADDR_W-1:0]   place_r, place_nxt;
  logic                coll_r, coll_nxt;
  logic                fb_r, fb_nxt;
  logic                socc_r, socc_nxt;
  logic [ID_W-1:0]     sent_r, sent_nxt;
  logic [CNT_W-1:0]    scol_r, scol_nxt;

  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_home_r, out_place_r;
  logic                out_coll_r, out_fb_r, out_socc_r;
  logic [ID_W-1:0]     out_sent_r;
  logic [CNT_W-1:0]    out_scol_r;

  logic [SUM_W-1:0]    fold_a, fold_b;

  alu_op_t             alu_op;
  logic [ALU_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_nb;

  store_req_t          sreq;
  logic                occ_hit;
  logic [ID_W-1:0]     ent_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_inc;

  assign mode_in  = mode_t'(in_mode);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (size_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_r > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = size_r;
    end
  end

  assign fold_a = SUM_W'(in_digit0) * SUM_W'(100) + SUM_W'(in_digit2) * SUM_W'(10)
                + SUM_W'(in_digit5);
  assign fold_b = SUM_W'(in_digit1) * SUM_W'(100) + SUM_W'(in_digit3) * SUM_W'(10)
                + SUM_W'(in_digit4);

  assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);

  fsht_alu u_alu (
    .op        (alu_op),
    .a         (alu_a),
    .b         (alu_b),
    .res       (alu_res),
    .no_borrow (alu_nb)
  );

  fsht_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .occ_hit (occ_hit),
    .ent_q   (ent_q),
    .cnt_q   (cnt_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_in)
            MODE_INSERT: state_nxt = ST_MOD;
            MODE_READ:   state_nxt = ST_RD;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MOD: begin
        if (bit_r == BITCNT_W'(SUM_W - 1)) begin
          state_nxt = ST_HOME;
        end
      end
      ST_HOME:    state_nxt = occ_hit ? ST_CNT_UPD : ST_PLACE;
      ST_CNT_UPD: state_nxt = ST_PADD;
      ST_PADD:    state_nxt = ST_PCHK;
      ST_PCHK: begin
        if (!alu_nb && occ_hit) begin
          state_nxt = ST_PADD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE:   state_nxt = ST_DONE;
      ST_RD:      state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // unit controls and store requests
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = ALU_W'(size_eff);
    sreq   = '0;
    sreq.ent_wdata = id_r;
    sreq.set_addr  = place_r;
    sreq.cnt_addr  = home_r;
    sreq.cnt_wdata = cnt_inc;
    sreq.rd_addr   = idx_r;
    sreq.prb_addr  = idx_r;
    case (state_r)
      ST_IDLE: begin
        sreq.clear_all = accept && (mode_in == MODE_CLEAR);
      end
      ST_MOD: begin
        alu_a = ALU_W'({rem_r, sum_r[SUM_W-1]});
      end
      ST_HOME: begin
        sreq.prb_addr = rem_r;
        sreq.rd_addr  = rem_r;
        sreq.rd_en    = 1'b1;
      end
      ST_CNT_UPD: begin
        sreq.cnt_we = 1'b1;
      end
      ST_PADD: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(j_r);
        alu_b  = PROBE_STEP;
      end
      ST_PCHK: begin
        alu_a         = ALU_W'(j_r);
        sreq.prb_addr = j_r[ADDR_W-1:0];
      end
      ST_PLACE: begin
        sreq.occ_set = 1'b1;
        sreq.ent_we  = 1'b1;
      end
      ST_RD: begin
        sreq.rd_en = 1'b1;
      end
      default: begin
        sreq.rd_en = 1'b0;
      end
    endcase
  end

  // working registers
  always_comb begin
    sum_nxt   = sum_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    j_nxt     = j_r;
    id_nxt    = id_r;
    idx_nxt   = idx_r;
    home_nxt  = home_r;
    place_nxt = place_r;
    coll_nxt  = coll_r;
    fb_nxt    = fb_r;
    socc_nxt  = socc_r;
    sent_nxt  = sent_r;
    scol_nxt  = scol_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sum_nxt   = fold_a + fold_b;
          rem_nxt   = '0;
          bit_nxt   = '0;
          id_nxt    = in_entry_id;
          idx_nxt   = in_slot_index;
          home_nxt  = '0;
          place_nxt = '0;
          coll_nxt  = 1'b0;
          fb_nxt    = 1'b0;
          socc_nxt  = 1'b0;
          sent_nxt  = '0;
          scol_nxt  = '0;
        end
      end
      ST_MOD: begin
        sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        bit_nxt = bit_r + BITCNT_W'(1);
        rem_nxt = alu_nb ? alu_res[ADDR_W-1:0] : alu_a[ADDR_W-1:0];
      end
      ST_HOME: begin
        home_nxt  = rem_r;
        place_nxt = rem_r;
        j_nxt     = SIZE_W'(rem_r);
        coll_nxt  = occ_hit;
      end
      ST_PADD: begin
        j_nxt = alu_res[SIZE_W-1:0];
      end
      ST_PCHK: begin
        if (alu_nb) begin
          place_nxt = '0;
          fb_nxt    = 1'b1;
        end else if (!occ_hit) begin
          place_nxt = j_r[ADDR_W-1:0];
        end
      end
      ST_RD: begin
        socc_nxt = occ_hit;
      end
      ST_RD_WAIT: begin
        sent_nxt = socc_r ? ent_q : '0;
        scol_nxt = cnt_q;
      end
      default: begin
        sum_nxt = sum_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    j_r     <= j_nxt;
    id_r    <= id_nxt;
    idx_r   <= idx_nxt;
    home_r  <= home_nxt;
    place_r <= place_nxt;
    coll_r  <= coll_nxt;
    fb_r    <= fb_nxt;
    socc_r  <= socc_nxt;
    sent_r  <= sent_nxt;
    scol_r  <= scol_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_home_r  <= home_r;
      out_place_r <= place_r;
      out_coll_r  <= coll_r;
      out_fb_r    <= fb_r;
      out_socc_r  <= socc_r;
      out_sent_r  <= sent_r;
      out_scol_r  <= scol_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_home_slot       = out_home_r;
  assign out_placed_slot     = out_place_r;
  assign out_collided        = out_coll_r;
  assign out_fell_back       = out_fb_r;
  assign out_slot_occupied   = out_socc_r;
  assign out_slot_entry      = out_sent_r;
  assign out_slot_collisions = out_scol_r;

endmodule

// ===== rtl/core/fsht_alu.sv =====
// shared add/subtract unit for remainder steps, probe stepping and probe bound checks
module fsht_alu
  import fsht_pkg::*;
(
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] res,
  output logic             no_borrow
);

  logic [ALU_W:0] full;

  always_comb begin
    if (op == ALU_SUB) begin
      full = {1'b0, a} + {1'b0, ~b} + {{ALU_W{1'b0}}, 1'b1};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign res       = full[ALU_W-1:0];
  assign no_borrow = full[ALU_W];

endmodule

// ===== rtl/core/fsht_store.sv =====
// slot storage: occupancy and count valid flags, entry and collision count memories
module fsht_store
  import fsht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  store_req_t       req,
  output logic             occ_hit,
  output logic [ID_W-1:0]  ent_q,
  output logic [CNT_W-1:0] cnt_q
);

  logic [SLOTS-1:0] occ_r;
  logic [SLOTS-1:0] cnt_vld_r;
  logic [ID_W-1:0]  ent_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];
  logic [ID_W-1:0]  ent_q_r;
  logic [CNT_W-1:0] cnt_q_r;
  logic             cnt_vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      cnt_vld_r <= '0;
    end else if (req.clear_all) begin
      occ_r     <= '0;
      cnt_vld_r <= '0;
    end else begin
      if (req.occ_set) begin
        occ_r[req.set_addr] <= 1'b1;
      end
      if (req.cnt_we) begin
        cnt_vld_r[req.cnt_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ent_we) begin
      ent_mem[req.set_addr] <= req.ent_wdata;
    end
    if (req.cnt_we) begin
      cnt_mem[req.cnt_addr] <= req.cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      ent_q_r     <= ent_mem[req.rd_addr];
      cnt_q_r     <= cnt_mem[req.rd_addr];
      cnt_vld_q_r <= cnt_vld_r[req.rd_addr];
    end
  end

  assign occ_hit = occ_r[req.prb_addr];
  assign ent_q   = ent_q_r;
  assign cnt_q   = cnt_vld_q_r ? cnt_q_r : '0;

endmodule
